// ----- rtl/ats_pkg.sv -----
// Package for the alert tone sequencer: pattern codes, shared structs and
// the note tables. It depends on nothing else.
package ats_pkg;

   // Tone patterns, as stored in the pattern register and reported per request.
   typedef enum logic [1:0] {
      PAT_NONE      = 2'd0,
      PAT_QUAKE     = 2'd1,
      PAT_COUNTDOWN = 2'd2,
      PAT_LIFTOFF   = 2'd3
   } ats_pattern_type;

   localparam int unsigned ID_BYTES = 15;
   localparam int unsigned ID_BITS  = 8 * ID_BYTES;

   // One poll request.
   typedef struct packed {
      logic [31:0]        now_ms;
      logic               quake_alert;
      logic               quake_id_present;
      logic [63:0]        quake_id_high;
      logic [55:0]        quake_id_low;
      logic               countdown_flag;
      logic               liftoff_flag;
      logic signed [63:0] launch_epoch;
   } ats_req_type;

   // One response.
   typedef struct packed {
      logic            tone_write;
      logic [10:0]     tone_hz;
      ats_pattern_type pattern_now;
   } ats_rsp_type;

   // Sequencer state carried from one request to the next.
   typedef struct packed {
      ats_pattern_type pattern;
      logic [2:0]      note_index;
      logic [31:0]     note_start_ms;
      logic [ID_BITS-1:0] last_id;
      logic [63:0]     last_countdown_epoch;
      logic [63:0]     last_liftoff_epoch;
   } ats_state_type;

   // Number of notes in a pattern.
   function automatic logic [2:0] note_count(input ats_pattern_type p);
      logic [2:0] n;
      unique case (p)
         PAT_QUAKE:     n = 3'd6;
         PAT_COUNTDOWN: n = 3'd2;
         PAT_LIFTOFF:   n = 3'd3;
         PAT_NONE:      n = 3'd0;
      endcase
      return n;
   endfunction

   // Sounding time of one note, in milliseconds.
   function automatic logic [7:0] sound_ms(input ats_pattern_type p);
      logic [7:0] t;
      unique case (p)
         PAT_QUAKE:     t = 8'd140;
         PAT_COUNTDOWN: t = 8'd110;
         PAT_LIFTOFF:   t = 8'd190;
         PAT_NONE:      t = 8'd0;
      endcase
      return t;
   endfunction

   // Silence after one note, in milliseconds.
   function automatic logic [6:0] quiet_ms(input ats_pattern_type p);
      logic [6:0] t;
      unique case (p)
         PAT_QUAKE:     t = 7'd90;
         PAT_COUNTDOWN: t = 7'd80;
         PAT_LIFTOFF:   t = 7'd70;
         PAT_NONE:      t = 7'd0;
      endcase
      return t;
   endfunction

   // Frequency of a note within a pattern, in hertz.
   function automatic logic [10:0] note_hz(input ats_pattern_type p, input logic [2:0] idx);
      logic [10:0] hz;
      hz = 11'd0;
      unique case (p)
         PAT_QUAKE: begin
            hz = idx[0] ? 11'd880 : 11'd660;
         end
         PAT_COUNTDOWN: begin
            case (idx)
               3'd0:    hz = 11'd1047;
               3'd1:    hz = 11'd1319;
               default: hz = 11'd0;
            endcase
         end
         PAT_LIFTOFF: begin
            case (idx)
               3'd0:    hz = 11'd784;
               3'd1:    hz = 11'd1047;
               3'd2:    hz = 11'd1568;
               default: hz = 11'd0;
            endcase
         end
         PAT_NONE: hz = 11'd0;
      endcase
      return hz;
   endfunction

endpackage

// ----- rtl/ats_channels.sv -----
// Valid/ready channel interfaces for poll requests and responses.
// It depends on nothing else.
interface ats_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        now_ms;
   logic               quake_alert;
   logic               quake_id_present;
   logic [63:0]        quake_id_high;
   logic [55:0]        quake_id_low;
   logic               countdown_flag;
   logic               liftoff_flag;
   logic signed [63:0] launch_epoch;

   modport source (
      output valid, now_ms, quake_alert, quake_id_present, quake_id_high,
             quake_id_low, countdown_flag, liftoff_flag, launch_epoch,
      input  ready
   );
   modport sink (
      input  valid, now_ms, quake_alert, quake_id_present, quake_id_high,
             quake_id_low, countdown_flag, liftoff_flag, launch_epoch,
      output ready
   );
endinterface

interface ats_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     tone_write;
   logic [10:0]              tone_hz;
   logic [1:0]               pattern_now;

   modport source (
      output valid, tone_write, tone_hz, pattern_now,
      input  ready
   );
   modport sink (
      input  valid, tone_write, tone_hz, pattern_now,
      output ready
   );
endinterface

// ----- rtl/ats_step.sv -----
// Combinational step of the alert tone sequencer: next state and response
// for one poll request. Depends on ats_pkg for types and note tables.
module ats_step (
   input  ats_pkg::ats_req_type   req,
   input  ats_pkg::ats_state_type cur,
   output ats_pkg::ats_state_type nxt,
   output ats_pkg::ats_rsp_type   rsp
);

   logic [ats_pkg::ID_BITS-1:0] id_raw;
   logic [ats_pkg::ID_BITS-1:0] id_norm;
   logic [ats_pkg::ID_BYTES-1:0] id_alive;
   logic        id_nonempty;
   logic        epoch_pos;
   logic        start_quake;
   logic        start_liftoff;
   logic        start_countdown;
   logic [31:0] start_eff;
   logic [31:0] elapsed;
   logic [2:0]  count;
   logic [8:0]  total_ms;

   // Id normalization: every byte after the first zero byte reads as zero.
   always_comb begin
      id_raw = {req.quake_id_high, req.quake_id_low};
      id_alive[0] = 1'b1;
      for (int i = 1; i < ats_pkg::ID_BYTES; i++) begin
         id_alive[i] = id_alive[i-1] &&
                       (id_raw[ats_pkg::ID_BITS-1-8*(i-1) -: 8] != 8'd0);
      end
      for (int i = 0; i < ats_pkg::ID_BYTES; i++) begin
         id_norm[ats_pkg::ID_BITS-1-8*i -: 8] =
            id_alive[i] ? id_raw[ats_pkg::ID_BITS-1-8*i -: 8] : 8'd0;
      end
   end

   // Event start conditions, in priority order.
   assign id_nonempty = req.quake_id_present &&
                        (id_raw[ats_pkg::ID_BITS-1 -: 8] != 8'd0);
   assign epoch_pos   = (req.launch_epoch != 64'sd0) && !req.launch_epoch[63];
   assign start_quake = req.quake_alert && id_nonempty && (id_norm != cur.last_id);
   assign start_liftoff = req.liftoff_flag && epoch_pos &&
                          (req.launch_epoch != cur.last_liftoff_epoch);
   assign start_countdown = req.countdown_flag && epoch_pos &&
                            (req.launch_epoch != cur.last_countdown_epoch);

   // Note timing. A zero start time means the note has not started yet.
   assign start_eff = (cur.note_start_ms == 32'd0) ? req.now_ms : cur.note_start_ms;
   assign elapsed   = req.now_ms - start_eff;
   assign count     = ats_pkg::note_count(cur.pattern);
   assign total_ms  = {1'b0, ats_pkg::sound_ms(cur.pattern)} +
                      {2'b00, ats_pkg::quiet_ms(cur.pattern)};

   // Next state and response.
   always_comb begin
      nxt = cur;
      rsp.tone_write = 1'b0;
      rsp.tone_hz    = 11'd0;
      if (cur.pattern != ats_pkg::PAT_NONE) begin
         nxt.note_start_ms = start_eff;
         if (cur.note_index < count) begin
            if (elapsed < {24'd0, ats_pkg::sound_ms(cur.pattern)}) begin
               rsp.tone_write = 1'b1;
               rsp.tone_hz    = ats_pkg::note_hz(cur.pattern, cur.note_index);
            end else if (elapsed < {23'd0, total_ms}) begin
               rsp.tone_write = 1'b1;
            end else begin
               nxt.note_index    = cur.note_index + 3'd1;
               nxt.note_start_ms = req.now_ms;
            end
         end
         // End of pattern: silence and return to idle.
         if (nxt.note_index >= count) begin
            rsp.tone_write = 1'b1;
            rsp.tone_hz    = 11'd0;
            nxt.pattern    = ats_pkg::PAT_NONE;
         end
      end else begin
         if (start_quake) begin
            nxt.last_id = id_norm;
            nxt.pattern = ats_pkg::PAT_QUAKE;
         end else if (start_liftoff) begin
            nxt.last_liftoff_epoch = req.launch_epoch;
            nxt.pattern = ats_pkg::PAT_LIFTOFF;
         end else if (start_countdown) begin
            nxt.last_countdown_epoch = req.launch_epoch;
            nxt.pattern = ats_pkg::PAT_COUNTDOWN;
         end
         if (start_quake || start_liftoff || start_countdown) begin
            nxt.note_index    = 3'd0;
            nxt.note_start_ms = 32'd0;
         end
      end
      rsp.pattern_now = nxt.pattern;
   end

endmodule

// ----- rtl/alert_tone_sequencer.sv -----
// Alert tone sequencer: each poll request gives exactly one response.
// An accepted request is held in an input register, and the step logic loads the
// response register from it when that register is empty or its response is taken.
// One request is accepted every cycle; a held response stalls the input register only when
// it is full. Synchronous reset returns to idle with empty last id and zero last epochs.
// Depends on ats_pkg, ats_channels and ats_step.
module alert_tone_sequencer (
   input  logic          clock,
   input  logic          reset,
   ats_req_if.sink       req_chan,
   ats_rsp_if.source     rsp_chan
);

   logic                   stage_valid_ff;
   logic                   stage_valid_in;
   ats_pkg::ats_req_type   stage_data_ff;
   ats_pkg::ats_req_type   req_data;
   ats_pkg::ats_state_type state_ff;
   ats_pkg::ats_state_type state_in;
   ats_pkg::ats_rsp_type   rsp_data_ff;
   ats_pkg::ats_rsp_type   step_rsp;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   out_free;
   logic                   advance;
   logic                   req_take;

   // Handshake control.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = stage_valid_ff && out_free;
   assign req_chan.ready = !stage_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign stage_valid_in = req_take || (stage_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_chan.ready);

   // Gather the request fields.
   assign req_data.now_ms           = req_chan.now_ms;
   assign req_data.quake_alert      = req_chan.quake_alert;
   assign req_data.quake_id_present = req_chan.quake_id_present;
   assign req_data.quake_id_high    = req_chan.quake_id_high;
   assign req_data.quake_id_low     = req_chan.quake_id_low;
   assign req_data.countdown_flag   = req_chan.countdown_flag;
   assign req_data.liftoff_flag     = req_chan.liftoff_flag;
   assign req_data.launch_epoch     = req_chan.launch_epoch;

   // Step logic for the request in the input register.
   ats_step u_step (
      .req (stage_data_ff),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   // Control and sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tone_write  = rsp_data_ff.tone_write;
   assign rsp_chan.tone_hz     = rsp_data_ff.tone_hz;
   assign rsp_chan.pattern_now = rsp_data_ff.pattern_now;

endmodule

// ----- dv/alert_tone_sequencer_tb.sv -----
// Self-checking testbench for the alert tone sequencer: poll requests in, one response out.
// It depends on ats_pkg, the ats_req_if/ats_rsp_if channels and the alert_tone_sequencer RTL.
module alert_tone_sequencer_tb;

   localparam logic [63:0]  EPOCH_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]  EPOCH_MIN   = 64'h8000_0000_0000_0000;
   localparam logic [119:0] ID_ALL_ONES = {120{1'b1}};
   localparam int           QUIET_LIMIT = 2000;

   typedef struct packed {
      logic                 drain_first;
      ats_pkg::ats_req_type poll;
   } pending_poll_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ats_req_if poll_req ();
   ats_rsp_if tone_rsp ();

   // Testbench-owned copies of the driven signals, known from time zero.
   ats_pkg::ats_req_type req_drive = '0;
   logic                 req_valid = 1'b0;
   logic                 rsp_ready = 1'b0;

   assign poll_req.valid = req_valid;
   assign {poll_req.now_ms, poll_req.quake_alert, poll_req.quake_id_present,
           poll_req.quake_id_high, poll_req.quake_id_low, poll_req.countdown_flag,
           poll_req.liftoff_flag, poll_req.launch_epoch} = req_drive;
   assign tone_rsp.ready = rsp_ready;

   alert_tone_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (poll_req),
      .rsp_chan (tone_rsp)
   );

   // Sequencer state as the testbench sees it.
   ats_pkg::ats_pattern_type play_pat        = ats_pkg::PAT_NONE;
   logic [2:0]               play_note       = 3'd0;
   logic [31:0]              play_start      = 32'd0;
   logic [119:0]             heard_id        = '0;
   logic [63:0]              heard_countdown = '0;
   logic [63:0]              heard_liftoff   = '0;

   ats_pkg::ats_rsp_type tone_expect_q[$];
   pending_poll_type     pending_q[$];
   logic [119:0]         id_pool [4];
   logic [63:0]          epoch_pool [4];

   int polls_issued = 0;
   int polls_taken  = 0;
   int send_gap     = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;
   int mismatches   = 0;

   // Every third stretch of 200 requests runs with no random gaps on either side.
   wire calm = ((polls_taken / 200) % 3) == 1;

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly back-to-back, sometimes a short gap, rarely a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic push_poll(input bit drain_first, input logic [31:0] now, input bit qa,
                            input bit qp, input logic [119:0] id, input bit cd, input bit lf,
                            input logic [63:0] ep);
      pending_poll_type slot;
      slot.drain_first           = drain_first;
      slot.poll.now_ms           = now;
      slot.poll.quake_alert      = qa;
      slot.poll.quake_id_present = qp;
      slot.poll.quake_id_high    = id[119:56];
      slot.poll.quake_id_low     = id[55:0];
      slot.poll.countdown_flag   = cd;
      slot.poll.liftoff_flag     = lf;
      slot.poll.launch_epoch     = ep;
      pending_q.push_back(slot);
   endtask

   // Advance the sequencer by one poll and queue the tone response it must give.
   task automatic predict_tone(input ats_pkg::ats_req_type p);
      ats_pkg::ats_rsp_type r;
      logic [31:0] since;
      logic [31:0] ring;
      logic [31:0] rest;
      logic [2:0]  count;
      logic [119:0] id;
      logic        ended;
      logic        epoch_ok;
      logic        started;
      int          k;
      r = '0;
      if (play_pat != ats_pkg::PAT_NONE) begin
         case (play_pat)
            ats_pkg::PAT_QUAKE: begin
               count = 3'd6; ring = 32'd140; rest = 32'd90;
            end
            ats_pkg::PAT_COUNTDOWN: begin
               count = 3'd2; ring = 32'd110; rest = 32'd80;
            end
            default: begin
               count = 3'd3; ring = 32'd190; rest = 32'd70;
            end
         endcase
         // A note start of zero means the note has not begun yet.
         if (play_start == 32'd0) play_start = p.now_ms;
         if (play_note < count) begin
            since = p.now_ms - play_start;
            if (since < ring) begin
               r.tone_write = 1'b1;
               case (play_pat)
                  ats_pkg::PAT_QUAKE: r.tone_hz = play_note[0] ? 11'd880 : 11'd660;
                  ats_pkg::PAT_COUNTDOWN: begin
                     r.tone_hz = (play_note == 3'd0) ? 11'd1047 : 11'd1319;
                  end
                  default: begin
                     if (play_note == 3'd0)      r.tone_hz = 11'd784;
                     else if (play_note == 3'd1) r.tone_hz = 11'd1047;
                     else                        r.tone_hz = 11'd1568;
                  end
               endcase
            end else if (since < ring + rest) begin
               r.tone_write = 1'b1;
            end else begin
               play_note  = play_note + 3'd1;
               play_start = p.now_ms;
            end
         end
         // The last note done: write silence and go idle.
         if (play_note >= count) begin
            r.tone_write = 1'b1;
            r.tone_hz    = 11'd0;
            play_pat     = ats_pkg::PAT_NONE;
         end
      end else begin
         // The id ends at its first zero byte; anything after it does not count.
         id    = {p.quake_id_high, p.quake_id_low};
         ended = 1'b0;
         for (k = 0; k < 15; k++) begin
            if (ended) id[119 - 8*k -: 8] = 8'h00;
            else if (id[119 - 8*k -: 8] == 8'h00) ended = 1'b1;
         end
         epoch_ok = !p.launch_epoch[63] && (p.launch_epoch != 64'd0);
         started  = 1'b1;
         if (p.quake_alert && p.quake_id_present && id[119:112] != 8'h00 &&
             id != heard_id) begin
            heard_id = id;
            play_pat = ats_pkg::PAT_QUAKE;
         end else if (p.liftoff_flag && epoch_ok && p.launch_epoch != heard_liftoff) begin
            heard_liftoff = p.launch_epoch;
            play_pat      = ats_pkg::PAT_LIFTOFF;
         end else if (p.countdown_flag && epoch_ok && p.launch_epoch != heard_countdown) begin
            heard_countdown = p.launch_epoch;
            play_pat        = ats_pkg::PAT_COUNTDOWN;
         end else begin
            started = 1'b0;
         end
         if (started) begin
            play_note  = 3'd0;
            play_start = 32'd0;
         end
      end
      r.pattern_now = play_pat;
      tone_expect_q.push_back(r);
   endtask

   // Request driver: one request on the bus at a time, random gaps between them.
   always @(negedge clock) begin
      pending_poll_type next_poll;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (polls_issued == polls_taken) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain_first && tone_expect_q.size() > 0)) begin
               next_poll    = pending_q.pop_front();
               req_drive    <= next_poll.poll;
               polls_issued = polls_issued + 1;
               send_gap     = pick_gap();
            end
         end
         req_valid <= (polls_issued != polls_taken);
      end
   end

   // Response side back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // Monitor: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin
      ats_pkg::ats_rsp_type want;
      if (!reset) begin
         quiet_cycles = quiet_cycles + 1;
         if (poll_req.valid && poll_req.ready) begin
            predict_tone(req_drive);
            polls_taken  = polls_taken + 1;
            quiet_cycles = 0;
         end
         if (tone_rsp.valid && tone_rsp.ready) begin
            quiet_cycles = 0;
            if (tone_expect_q.size() == 0) begin
               $display("%0t: unexpected response: write %0b hz %0d pattern %0d", $time,
                        tone_rsp.tone_write, tone_rsp.tone_hz, tone_rsp.pattern_now);
               mismatches = mismatches + 1;
            end else begin
               want = tone_expect_q.pop_front();
               if (tone_rsp.tone_write !== want.tone_write ||
                   tone_rsp.tone_hz !== want.tone_hz ||
                   tone_rsp.pattern_now !== want.pattern_now) begin
                  $display({"%0t: expected write %0b hz %0d pattern %0d, ",
                            "got write %0b hz %0d pattern %0d"},
                           $time, want.tone_write, want.tone_hz, want.pattern_now,
                           tone_rsp.tone_write, tone_rsp.tone_hz, tone_rsp.pattern_now);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("alert_tone_sequencer regression: fail");
            $finish;
         end
      end
   end

   // Stimulus, reset and end of test.
   initial begin
      int           n;
      int           k;
      int           len;
      int           sel;
      logic [31:0]  sim_ms;
      logic [127:0] wide;
      logic [119:0] id;
      logic [63:0]  ep;
      bit           qa;
      bit           qp;
      bit           cd;
      bit           lf;
      bit           ended;
      bit           clean_tail;

      // Directed: empty ids, non-positive epochs, a note started at time zero,
      // exact note and silence edges, wrap of elapsed time and event priority.
      push_poll(1'b0, 32'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
      push_poll(1'b0, 32'd1, 1'b1, 1'b0, ID_ALL_ONES, 1'b1, 1'b1, EPOCH_MIN);
      push_poll(1'b0, 32'd2, 1'b1, 1'b1, {8'h00, {112{1'b1}}}, 1'b1, 1'b1, 64'd0);
      push_poll(1'b0, 32'd3, 1'b0, 1'b1, ID_ALL_ONES, 1'b1, 1'b0, EPOCH_MAX);
      push_poll(1'b0, 32'd0, 1'b1, 1'b1, ID_ALL_ONES, 1'b1, 1'b1, 64'd5);
      push_poll(1'b0, 32'd100, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
      push_poll(1'b0, 32'd209, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
      push_poll(1'b0, 32'd210, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
      push_poll(1'b0, 32'd289, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
      push_poll(1'b0, 32'd290, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
      push_poll(1'b0, 32'd399, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
      push_poll(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
      push_poll(1'b0, 32'd5, 1'b0, 1'b0, '0, 1'b1, 1'b0, EPOCH_MAX);
      push_poll(1'b0, 32'd6, 1'b1, 1'b1, ID_ALL_ONES, 1'b1, 1'b1, EPOCH_MAX);
      push_poll(1'b0, 32'd1000, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
      for (k = 0; k < 6; k++) begin
         push_poll(1'b0, 32'(1230 + 230 * k), 1'b0, 1'b0, '0, 1'b0, 1'b0, '0);
      end
      push_poll(1'b1, 32'd2400, 1'b1, 1'b1, ID_ALL_ONES, 1'b0, 1'b0, '0);
      push_poll(1'b0, 32'd2500, 1'b1, 1'b1, {64'h4100_DEAD_BEEF_0123, 56'h12_3456_789A_BCDE},
                1'b1, 1'b1, 64'd1);

      for (k = 0; k < 4; k++) begin
         id_pool[k]    = '0;
         epoch_pool[k] = {1'b0, 31'($urandom()), $urandom()};
      end

      // Random: a clock that mostly creeps forward so patterns play out, with
      // jumps, wraps and zero times, and events that often repeat earlier ones.
      sim_ms = 32'd2500;
      for (n = 0; n < 1630; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 70)      sim_ms = sim_ms + $urandom_range(0, 40);
         else if (sel < 90) sim_ms = sim_ms + $urandom_range(41, 300);
         else if (sel < 95) sim_ms = $urandom();
         else if (sel < 98) sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
         else               sim_ms = 32'd0;

         qa = ($urandom_range(0, 3) == 0);
         qp = ($urandom_range(0, 7) != 0);
         cd = ($urandom_range(0, 2) == 0);
         lf = ($urandom_range(0, 3) == 0);

         wide = {$urandom(), $urandom(), $urandom(), $urandom()};
         sel  = $urandom_range(0, 7);
         if (sel == 0) begin
            id = wide[119:0];
         end else if (sel < 3) begin
            // A string of nonzero bytes, its terminator, then maybe garbage.
            id         = wide[119:0];
            len        = $urandom_range(0, 15);
            clean_tail = 1'($urandom_range(0, 1));
            for (k = 0; k < 15; k++) begin
               if (k < len) begin
                  if (id[119 - 8*k -: 8] == 8'h00) id[119 - 8*k -: 8] = 8'h5A;
               end else if (k == len || clean_tail) begin
                  id[119 - 8*k -: 8] = 8'h00;
               end
            end
            id_pool[2'($urandom_range(0, 3))] = id;
         end else begin
            // A known id with fresh garbage after its terminator.
            id    = id_pool[2'($urandom_range(0, 3))];
            ended = 1'b0;
            for (k = 0; k < 15; k++) begin
               if (ended) begin
                  if ($urandom_range(0, 1) == 1) begin
                     id[119 - 8*k -: 8] = 8'($urandom_range(0, 255));
                  end
               end else if (id[119 - 8*k -: 8] == 8'h00) begin
                  ended = 1'b1;
               end
            end
         end

         sel = $urandom_range(0, 15);
         if (sel < 2) begin
            ep = {$urandom(), $urandom()};
         end else if (sel < 4) begin
            ep = {1'b0, 31'($urandom()), $urandom()};
            epoch_pool[2'($urandom_range(0, 3))] = ep;
         end else if (sel < 5) begin
            case ($urandom_range(0, 3))
               0:       ep = 64'd0;
               1:       ep = 64'd1;
               2:       ep = EPOCH_MAX;
               default: ep = EPOCH_MIN;
            endcase
         end else begin
            ep = epoch_pool[2'($urandom_range(0, 3))];
         end

         push_poll((n % 400) == 200, sim_ms, qa, qp, id, cd, lf, ep);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || polls_issued != polls_taken || tone_expect_q.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("alert_tone_sequencer regression: pass");
      end else begin
         $display("alert_tone_sequencer regression: fail");
      end
      $finish;
   end

endmodule
